// File: sv/pwmc_pkg.sv
`timescale 1ns / 1ps
package pwmc_pkg;

  // Fixed geometry of the register map
  localparam int CH_COUNT         = 16;
  localparam int CH_BYTES         = 64;
  localparam int CH_IDX_W         = 6;
  localparam int COUNTER_BITS_DEF = 12;
  localparam int TIME_W           = 12;

  // Register addresses
  localparam logic [7:0] ADDR_MODE1    = 8'h00;
  localparam logic [7:0] ADDR_MODE2    = 8'h01;
  localparam logic [7:0] ADDR_CH_BASE  = 8'h06;
  localparam logic [7:0] ADDR_CH_LAST  = 8'h45;
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

  // Register bits and masks
  localparam logic [7:0] BIT_RESTART  = 8'h80;
  localparam logic [7:0] BIT_AUTOINC  = 8'h20;
  localparam logic [7:0] BIT_SLEEP    = 8'h10;
  localparam logic [7:0] BIT_FULL     = 8'h10;
  localparam logic [7:0] HIGH_MASK    = 8'h1F;
  localparam logic [7:0] PRESCALE_MIN = 8'h03;

  // Reset values
  localparam logic [7:0] MODE1_RST    = 8'h11;
  localparam logic [7:0] MODE2_RST    = 8'h04;
  localparam logic [7:0] PRESCALE_RST = 8'h1E;

  typedef enum logic [1:0] {
    MODE_PTR   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_TICK  = 2'd3
  } item_mode_t;

  typedef struct packed {
    item_mode_t mode;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pwm_levels;
  } out_item_t;

endpackage

// File: sv/pwmc_lane.sv
`timescale 1ns / 1ps
module pwmc_lane #(
  parameter int CNT_W = pwmc_pkg::COUNTER_BITS_DEF
) (
  input  logic [7:0]       on_l,
  input  logic [7:0]       on_h,
  input  logic [7:0]       off_l,
  input  logic [7:0]       off_h,
  input  logic [CNT_W-1:0] count,
  output logic             level
);
  import pwmc_pkg::*;

  localparam int CMP_W = (CNT_W > TIME_W) ? CNT_W : TIME_W;

  logic [CMP_W-1:0] on_t;
  logic [CMP_W-1:0] off_t;
  logic [CMP_W-1:0] cnt_t;

  // Widen on/off times and counter to a common compare width
  assign on_t  = CMP_W'({on_h[3:0], on_l});
  assign off_t = CMP_W'({off_h[3:0], off_l});
  assign cnt_t = CMP_W'(count);

  // Full-off wins over full-on, then the window compare
  always_comb begin
    if ((off_h & BIT_FULL) != 8'h00) begin
      level = 1'b0;
    end else if ((on_h & BIT_FULL) != 8'h00) begin
      level = 1'b1;
    end else if (on_t < off_t) begin
      level = (cnt_t >= on_t) && (cnt_t < off_t);
    end else if (on_t > off_t) begin
      level = (cnt_t >= on_t) || (cnt_t < off_t);
    end else begin
      level = 1'b0;
    end
  end

endmodule

// File: sv/pwm_controller_16ch_12bit_core.sv
`timescale 1ns / 1ps
// Register-level sixteen-channel PWM controller. Each input beat is a pointer
// load, a byte write, a byte read or one oscillator tick; each produces exactly
// one result beat with the read byte and the sixteen channel levels after it.
// The core takes one beat per clock and returns its result through the input
// register, then the result register; the state update for a beat is applied
// as the beat leaves the input register, so a new beat can follow every cycle
// while the output side keeps taking results.
module pwm_controller_16ch_12bit_core #(
  parameter int COUNTER_BITS = pwmc_pkg::COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pwmc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pwmc_pkg::out_item_t out_data
);
  import pwmc_pkg::*;

  // Input register and result register
  in_item_t  in_r;
  logic      in_v_r;
  out_item_t out_r;
  logic      out_v_r;
  logic      adv;

  // Device state
  logic [7:0]              mode_one_r, mode_one_nxt;
  logic [7:0]              mode_two_r, mode_two_nxt;
  logic [7:0]              ch_bytes_r   [CH_BYTES];
  logic [7:0]              ch_bytes_nxt [CH_BYTES];
  logic [7:0]              div_set_r, div_set_nxt;
  logic [7:0]              div_cnt_r, div_cnt_nxt;
  logic [COUNTER_BITS-1:0] period_r, period_nxt;
  logic [7:0]              ptr_r, ptr_nxt;

  logic [CH_IDX_W-1:0] ch_idx;
  logic                ptr_in_ch;
  logic [7:0]          rd_byte;
  logic [7:0]          rd_nxt;
  logic [15:0]         levels;

  // Move a beat forward when the result slot is free or being drained
  assign adv       = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r.read_data  <= rd_nxt;
      out_r.pwm_levels <= levels;
    end
  end

  // Decode the pointer into the channel byte space
  assign ptr_in_ch = ptr_r inside {[ADDR_CH_BASE:ADDR_CH_LAST]};
  assign ch_idx    = CH_IDX_W'(ptr_r - ADDR_CH_BASE);

  // Read back the byte at the pointer
  always_comb begin
    if (ptr_r == ADDR_MODE1) begin
      rd_byte = mode_one_r;
    end else if (ptr_r == ADDR_MODE2) begin
      rd_byte = mode_two_r;
    end else if (ptr_in_ch) begin
      rd_byte = ch_bytes_r[ch_idx];
    end else if (ptr_r == ADDR_PRESCALE) begin
      rd_byte = div_set_r;
    end else begin
      rd_byte = 8'h00;
    end
  end

  // Apply one beat to the device state
  always_comb begin
    mode_one_nxt = mode_one_r;
    mode_two_nxt = mode_two_r;
    ch_bytes_nxt = ch_bytes_r;
    div_set_nxt  = div_set_r;
    div_cnt_nxt  = div_cnt_r;
    period_nxt   = period_r;
    ptr_nxt      = ptr_r;
    rd_nxt       = 8'h00;
    if (adv) begin
      case (in_r.mode)
        MODE_PTR: begin
          ptr_nxt = in_r.reg_addr;
        end
        MODE_WRITE: begin
          if (ptr_r == ADDR_MODE1) begin
            if ((in_r.write_data & BIT_RESTART) != 8'h00) begin
              div_cnt_nxt = 8'h00;
              period_nxt  = '0;
            end
            mode_one_nxt = in_r.write_data & ~BIT_RESTART;
          end else if (ptr_r == ADDR_MODE2) begin
            mode_two_nxt = in_r.write_data;
          end else if (ptr_in_ch) begin
            ch_bytes_nxt[ch_idx] = ch_idx[0] ? (in_r.write_data & HIGH_MASK)
                                             : in_r.write_data;
          end else if (ptr_r == ADDR_PRESCALE) begin
            if ((mode_one_r & BIT_SLEEP) != 8'h00) begin
              div_set_nxt = (in_r.write_data < PRESCALE_MIN) ? PRESCALE_MIN
                                                              : in_r.write_data;
            end
          end
          // Auto-increment follows MODE1 as it stands after this write
          if ((mode_one_nxt & BIT_AUTOINC) != 8'h00) begin
            ptr_nxt = ptr_r + 8'd1;
          end
        end
        MODE_READ: begin
          rd_nxt = rd_byte;
          if ((mode_one_r & BIT_AUTOINC) != 8'h00) begin
            ptr_nxt = ptr_r + 8'd1;
          end
        end
        MODE_TICK: begin
          if ((mode_one_r & BIT_SLEEP) == 8'h00) begin
            if (div_cnt_r >= div_set_r) begin
              div_cnt_nxt = 8'h00;
              period_nxt  = period_r + COUNTER_BITS'(1);
            end else begin
              div_cnt_nxt = div_cnt_r + 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold device state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_one_r <= MODE1_RST;
      mode_two_r <= MODE2_RST;
      div_set_r  <= PRESCALE_RST;
      div_cnt_r  <= 8'h00;
      period_r   <= '0;
      ptr_r      <= 8'h00;
      for (int i = 0; i < CH_BYTES; i++) begin
        ch_bytes_r[i] <= ((i % 4) == 3) ? BIT_FULL : 8'h00;
      end
    end else begin
      mode_one_r <= mode_one_nxt;
      mode_two_r <= mode_two_nxt;
      div_set_r  <= div_set_nxt;
      div_cnt_r  <= div_cnt_nxt;
      period_r   <= period_nxt;
      ptr_r      <= ptr_nxt;
      ch_bytes_r <= ch_bytes_nxt;
    end
  end

  // Per-channel level lanes, evaluated on the post-beat state
  for (genvar n = 0; n < 16; n++) begin : g_lane
    if (n < CH_COUNT) begin : g_on
      pwmc_lane #(
        .CNT_W (COUNTER_BITS)
      ) u_lane (
        .on_l  (ch_bytes_nxt[4*n]),
        .on_h  (ch_bytes_nxt[4*n+1]),
        .off_l (ch_bytes_nxt[4*n+2]),
        .off_h (ch_bytes_nxt[4*n+3]),
        .count (period_nxt),
        .level (levels[n])
      );
    end else begin : g_off
      assign levels[n] = 1'b0;
    end
  end

  // Restart bit never sticks in MODE1
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_one_r & BIT_RESTART) == 8'h00)
    else $error("MODE1 restart bit stored");

  // Counters move only on an awake tick or a MODE1 write
  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && in_r.mode == MODE_TICK && (mode_one_r & BIT_SLEEP) == 8'h00) &&
    !(adv && in_r.mode == MODE_WRITE && ptr_r == ADDR_MODE1)
    |=> $stable(period_r) && $stable(div_cnt_r))
    else $error("counters changed without an awake tick or restart");

  // A result appears only after a beat moved out of the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(adv))
    else $error("result raised without a processed beat");

endmodule
